FILE: src/bns_pkg.sv
// Shared types and constants for the buzzer note sequencer.
// No dependencies; every other file refers to this package by scoped name.
package bns_pkg;

    // Field widths fixed by the item formats
    localparam int NOTE_W   = 8;
    localparam int DUR_W    = 8;
    localparam int PHASE_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VARIO_TONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIO_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIO_FILL   = 2'd2;

    // Register reset values
    localparam logic [NOTE_W-1:0]  VARIO_TONE_RST   = 8'd0;
    localparam logic [PHASE_W-1:0] VARIO_PERIOD_RST = 16'd800;
    localparam logic [PHASE_W-1:0] VARIO_FILL_RST   = 16'd50;

    localparam logic [NOTE_W-1:0]  TONE_SILENT = 8'h00;

    // Item operation codes
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_ENQ  = 1'b1
    } t_op;

    // Input item as seen on the ports
    typedef struct packed {
        logic              op;
        logic [NOTE_W-1:0] note_code;
        logic [DUR_W-1:0]  duration_ms;
    } t_in_item;

    // Classified command between front and back
    typedef struct packed {
        t_op               op;
        logic [NOTE_W-1:0] note_code;
        logic [DUR_W-1:0]  duration_ms;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [NOTE_W-1:0] tone_now;
        logic              tone_written;
        logic              busy_res;
        logic              dropped;
    } t_res_item;

    // Status from the back end
    typedef struct packed {
        logic exec;     // a command was carried out this cycle
        logic drop;     // that command was an enqueue that was discarded
        logic nq_full;  // note queue holds its full depth
    } t_back_stat;

endpackage

FILE: src/bns_front.sv
// Front end: accepts input items, classifies them and holds them in a
// two-entry command queue. Depends on bns_pkg.
module bns_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  bns_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    output bns_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);

    bns_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_cnt, n_cnt;
    logic          accept, take;
    bns_pkg::t_cmd cmd_in;

    // Classify the incoming item
    always_comb begin
        cmd_in.op          = bns_pkg::t_op'(i_in_item.op);
        cmd_in.note_code   = i_in_item.note_code;
        cmd_in.duration_ms = i_in_item.duration_ms;
    end

    assign full        = (r_cnt == 2'd2);
    assign accept      = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign take        = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (take && !accept) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

FILE: src/bns_res_queue.sv
// Two-entry result queue that parts the back end from the result port.
// Depends on bns_pkg.
module bns_res_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bns_pkg::t_res_item i_item,
    output logic               o_ready,
    output logic               empty,
    input  logic               pop,
    output bns_pkg::t_res_item o_res_item
);

    bns_pkg::t_res_item r_slot [2];
    logic               r_wr_ptr, r_rd_ptr;
    logic [1:0]         r_cnt, n_cnt;
    logic               wr, rd;

    assign o_ready    = (r_cnt != 2'd2);
    assign empty      = (r_cnt == 2'd0);
    assign wr         = i_push && o_ready;
    assign rd         = pop && !empty;
    assign o_res_item = r_slot[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Store the result
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: src/bns_back.sv
// Back end: configuration registers, note queue, countdown and vario phase;
// carries out one command per cycle while the result queue has room. Depends on bns_pkg.
module bns_back #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bns_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_cmd_valid,
    input  bns_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_take,
    input  logic                             i_res_ready,
    output logic                             o_res_push,
    output bns_pkg::t_res_item               o_res,
    output bns_pkg::t_back_stat              o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = bns_pkg::NOTE_W + bns_pkg::DUR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Configuration
    logic [bns_pkg::NOTE_W-1:0]  r_vario_tone;
    logic [bns_pkg::PHASE_W-1:0] r_vario_period;
    logic [bns_pkg::PHASE_W-1:0] r_vario_fill;

    // Sequencer state
    logic [bns_pkg::DUR_W-1:0]   r_countdown, n_countdown;
    logic [bns_pkg::NOTE_W-1:0]  r_tone, n_tone;
    logic [bns_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [PTR_W-1:0]            r_head, n_head, r_tail;
    logic [CNT_W-1:0]            r_ncnt;

    // Note queue memory and registered head entry
    logic [ENT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] r_head_data;
    logic [ENT_W-1:0] wr_entry;

    logic                        exec, is_enq, q_full, enq, drop, tick;
    logic [bns_pkg::DUR_W-1:0]   cnt_dec, cnt_after;
    logic                        note_end, do_pop, vario_on, wrote;
    logic [bns_pkg::NOTE_W-1:0]  tone_mid, want;
    logic [bns_pkg::PHASE_W:0]   ph_inc;
    logic [bns_pkg::PHASE_W-1:0] ph_wrap;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Classify the command at the head of the command queue
    assign exec       = i_cmd_valid && i_res_ready;
    assign o_cmd_take = exec;
    assign is_enq     = (i_cmd.op == bns_pkg::OP_ENQ);
    assign q_full     = (r_ncnt == CNT_FULL);
    assign enq        = exec && is_enq && !q_full;
    assign drop       = exec && is_enq && q_full;
    assign tick       = exec && !is_enq;
    assign wr_entry   = {i_cmd.note_code, i_cmd.duration_ms};

    // Tick: count down, pop, step the vario phase, pick the tone
    always_comb begin
        cnt_dec   = (r_countdown != '0) ? r_countdown - 8'd1 : '0;
        note_end  = (r_countdown == 8'd1);
        do_pop    = (cnt_dec == '0) && (r_ncnt != '0);
        cnt_after = do_pop ? r_head_data[bns_pkg::DUR_W-1:0] : cnt_dec;
        if (do_pop) begin
            tone_mid = r_head_data[ENT_W-1:bns_pkg::DUR_W];
        end else if (note_end) begin
            tone_mid = bns_pkg::TONE_SILENT;
        end else begin
            tone_mid = r_tone;
        end

        ph_inc  = {1'b0, r_phase} + 17'd1;
        ph_wrap = (ph_inc >= {1'b0, r_vario_period}) ? '0 : ph_inc[bns_pkg::PHASE_W-1:0];
        want    = (ph_wrap <= r_vario_fill) ? r_vario_tone : bns_pkg::TONE_SILENT;

        vario_on = (cnt_after == '0);
        wrote    = note_end || do_pop || (vario_on && (tone_mid != want));
    end

    // Next state
    always_comb begin
        n_countdown = r_countdown;
        n_tone      = r_tone;
        n_phase     = r_phase;
        n_head      = r_head;
        if (tick) begin
            n_countdown = cnt_after;
            n_tone      = vario_on ? want : tone_mid;
            n_phase     = ph_wrap;
            if (do_pop) begin
                n_head = next_slot(r_head);
            end
        end
    end

    // Form the result
    always_comb begin
        o_res_push = exec;
        if (is_enq) begin
            o_res.tone_now     = r_tone;
            o_res.tone_written = 1'b0;
            o_res.busy_res     = (r_countdown != '0);
            o_res.dropped      = q_full;
        end else begin
            o_res.tone_now     = n_tone;
            o_res.tone_written = wrote;
            o_res.busy_res     = (cnt_after != '0);
            o_res.dropped      = 1'b0;
        end
        o_stat.exec    = exec;
        o_stat.drop    = drop;
        o_stat.nq_full = q_full;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vario_tone   <= bns_pkg::VARIO_TONE_RST;
            r_vario_period <= bns_pkg::VARIO_PERIOD_RST;
            r_vario_fill   <= bns_pkg::VARIO_FILL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bns_pkg::CFG_VARIO_TONE: begin
                    r_vario_tone <= i_cfg_data[bns_pkg::NOTE_W-1:0];
                end
                bns_pkg::CFG_VARIO_PERIOD: begin
                    r_vario_period <= i_cfg_data;
                end
                bns_pkg::CFG_VARIO_FILL: begin
                    r_vario_fill <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
            r_tone      <= bns_pkg::TONE_SILENT;
            r_phase     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_ncnt      <= '0;
        end else begin
            r_countdown <= n_countdown;
            r_tone      <= n_tone;
            r_phase     <= n_phase;
            r_head      <= n_head;
            if (enq) begin
                r_tail <= next_slot(r_tail);
                r_ncnt <= r_ncnt + CNT_W'(1);
            end else if (tick && do_pop) begin
                r_ncnt <= r_ncnt - CNT_W'(1);
            end
        end
    end

    // Write the note queue; fetch the next head entry, forwarding a new write
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_tail] <= wr_entry;
        end
        if (enq && (r_tail == n_head)) begin
            r_head_data <= wr_entry;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

endmodule

FILE: src/buzzer_note_sequencer_core.sv
// Top level of the buzzer note sequencer: front end, back end, result queue.
// Depends on bns_pkg, bns_front, bns_back and bns_res_queue.
//
//  channel   handshake          payload                       direction
//  input     push / full        i_in_item (op, note, dur)     in
//  result    empty / pop        o_res_item (tone, flags)      out
//  config    i_cfg_we           i_cfg_idx, i_cfg_data         in
//
// One item per cycle sustained while neither side stalls; the back end carries
// out each item in the cycle in which it takes it. An accepted item waits in
// the command queue until the back end takes it; its result then waits in the
// result queue until popped. Reset is synchronous and needs no clearing pass:
// note queue entries are only used after they are written. Either side may
// stall on its own; the two-entry queues keep the flow going meanwhile.
module buzzer_note_sequencer_core #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  bns_pkg::t_in_item              i_in_item,
    output logic                           empty,
    input  logic                           pop,
    output bns_pkg::t_res_item             o_res_item,
    input  logic                           i_cfg_we,
    input  logic [bns_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bns_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                cmd_valid, cmd_take, res_ready, res_push;
    bns_pkg::t_cmd       cmd;
    bns_pkg::t_res_item  res;
    bns_pkg::t_back_stat stat;

    // Accept and classify
    bns_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Carry out
    bns_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_ready (res_ready),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_stat      (stat)
    );

    // Hold results for the consumer
    bns_res_queue u_res_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_push),
        .i_item     (res),
        .o_ready    (res_ready),
        .empty      (empty),
        .pop        (pop),
        .o_res_item (o_res_item)
    );

`ifndef SYNTHESIS
    // The back end only takes a command that the front end holds
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from an empty command queue");

    // An accepted item is registered in the command queue, waiting for the back end
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> cmd_valid)
        else $error("accepted item missing from command queue");

    // An enqueue is discarded only when the note queue is full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.exec && stat.drop) |-> stat.nq_full)
        else $error("enqueue dropped while note queue had room");

    // Every carried-out command produces a result pushed into the result queue
    a_exec_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.exec |-> (res_push && res_ready))
        else $error("command carried out without room for its result");
`endif

endmodule
